/* design/region_table_address_decoder_unit_assert.svh */
// Assertion macros for the region table address decoder unit.
// Used by the top level; the assertions expect a clock clk and a reset rst_n in scope.
`ifndef REGION_TABLE_ADDRESS_DECODER_UNIT_ASSERT_SVH
`define REGION_TABLE_ADDRESS_DECODER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define RTAD_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("region table assertion failed");
`define RTAD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("region table assertion failed");
`else
`define RTAD_ASSERT(label, ante, cons)
`define RTAD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* design/rtad_pkg.sv */
// Package of the region table address decoder: codes, item type and
// back-end state type. No dependencies.
`timescale 1ns / 1ps

package rtad_pkg;

  localparam int REGIONS_DEF = 16;
  localparam int ADDR_W = 32;
  localparam int Q_DEPTH = 2;

  localparam logic [1:0] ACT_READ = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_MAP = 2'd2;
  localparam logic [1:0] ACT_UNMAP = 2'd3;

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_RESERVED = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NOT_MAPPED = 3'd1;
  localparam logic [2:0] ST_PERM = 3'd2;
  localparam logic [2:0] ST_OVERLAP = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;

  // Decoded item as it travels from the front end through the queue.
  typedef struct packed {
    logic is_access;
    logic need_wr;
    logic is_map;
    logic is_unmap;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W:0] end_addr;
    logic len_nz;
    logic [1:0] perm;
    logic [1:0] kind;
  } item_t;

  typedef enum logic {
    BK_IDLE,
    BK_EVAL
  } bk_state_t;

  // Back-end activity, watched by the top-level checks.
  typedef struct packed {
    logic pop;
    logic eval;
  } bk_mon_t;

endpackage

/* design/rtad_ifs.sv */
// Channel interfaces of the region table address decoder: request and result.
// Depends on rtad_pkg.
`timescale 1ns / 1ps

interface rtad_in_if
  import rtad_pkg::*;
();
  logic valid;
  logic ready;
  logic [1:0] action;
  logic [ADDR_W-1:0] address;
  logic [ADDR_W-1:0] region_size;
  logic [1:0] perm;
  logic [1:0] backing_kind;

  modport source (output valid, action, address, region_size, perm, backing_kind,
                  input ready);
  modport sink (input valid, action, address, region_size, perm, backing_kind,
                output ready);
endinterface

interface rtad_out_if
  import rtad_pkg::*;
();
  logic valid;
  logic ready;
  logic [2:0] status;
  logic hit;
  logic [3:0] region_index;
  logic [ADDR_W-1:0] offset;
  logic [1:0] kind_out;

  modport source (output valid, status, hit, region_index, offset, kind_out,
                  input ready);
  modport sink (input valid, status, hit, region_index, offset, kind_out,
                output ready);
endinterface

/* design/rtad_front.sv */
// Front end: accepts request transactions, decodes the action and prepares
// the region end address. Depends on rtad_pkg and rtad_in_if.
`timescale 1ns / 1ps

module rtad_front
  import rtad_pkg::*;
(
  rtad_in_if.sink in_ch,
  input  logic    q_full,
  output logic    push,
  output item_t   item
);

  assign in_ch.ready = !q_full;
  assign push = in_ch.valid && !q_full;

  always_comb begin
    item.is_access = (in_ch.action == ACT_READ) || (in_ch.action == ACT_WRITE);
    item.need_wr   = (in_ch.action == ACT_WRITE);
    item.is_map    = (in_ch.action == ACT_MAP);
    item.is_unmap  = (in_ch.action == ACT_UNMAP);
    item.addr      = in_ch.address;
    // The end is kept in 33 bits so a region that reaches the top never wraps.
    item.end_addr  = {1'b0, in_ch.address} + {1'b0, in_ch.region_size};
    item.len_nz    = (in_ch.region_size != '0);
    item.perm      = in_ch.perm;
    item.kind      = (in_ch.backing_kind == KIND_RESERVED) ? KIND_ALLOC : in_ch.backing_kind;
  end

endmodule

/* design/rtad_fifo.sv */
// Short queue of decoded items between the front and back ends.
// Depends on rtad_pkg.
`timescale 1ns / 1ps

module rtad_fifo
  import rtad_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t wr_item,
  input  logic  pop,
  output item_t rd_item,
  output logic  full,
  output logic  empty
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  item_t            mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full    = (count_r == CNT_W'(Q_DEPTH));
  assign empty   = (count_r == '0);
  assign rd_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

/* design/rtad_back.sv */
// Back end: holds the region table, compares an item against every slot,
// then selects, updates the table and registers the result.
// Depends on rtad_pkg and rtad_out_if.
`timescale 1ns / 1ps

module rtad_back
  import rtad_pkg::*;
#(
  parameter int REGIONS = REGIONS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  item_t       q_item,
  output bk_mon_t     mon,
  rtad_out_if.source  out_ch
);

  localparam int IDX_W = (REGIONS > 1) ? $clog2(REGIONS) : 1;

  bk_state_t state_r, state_nxt;

  // Region table. Only the valid bits are reset.
  logic [REGIONS-1:0] valid_r, valid_nxt;
  logic [ADDR_W-1:0]  base_r [REGIONS];
  logic [ADDR_W:0]    end_r  [REGIONS];
  logic               nz_r   [REGIONS];
  logic [1:0]         perm_r [REGIONS];
  logic [1:0]         kind_r [REGIONS];

  // First step: compare results held for the select step.
  item_t              item_r;
  logic [REGIONS-1:0] cov_r;
  logic               ovl_r;
  logic [REGIONS-1:0] cov_nxt;
  logic [REGIONS-1:0] ovl_vec;

  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         status_r, status_nxt;
  logic               hit_r, hit_nxt;
  logic [3:0]         index_r, index_nxt;
  logic [ADDR_W-1:0]  offset_r, offset_nxt;
  logic [1:0]         kind_out_r, kind_out_nxt;

  logic               hit_any, free_any;
  logic [IDX_W-1:0]   hit_idx, free_idx;
  logic               do_map, do_unmap;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (mon.pop) begin
          state_nxt = BK_EVAL;
        end
      end
      BK_EVAL: begin
        state_nxt = BK_IDLE;
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer. An item is taken only when the result register
  // will be free by the time the select step writes it.
  always_comb begin
    mon.pop  = 1'b0;
    mon.eval = 1'b0;
    case (state_r)
      BK_IDLE: begin
        mon.pop = !q_empty && (!out_valid_r || out_ch.ready);
      end
      BK_EVAL: begin
        mon.eval = 1'b1;
      end
      default: begin
        mon.pop  = 1'b0;
        mon.eval = 1'b0;
      end
    endcase
  end

  // Parallel compare of the queued item against every slot.
  always_comb begin
    for (int s = 0; s < REGIONS; s++) begin
      cov_nxt[s] = valid_r[s] && (q_item.addr >= base_r[s]) &&
                   ({1'b0, q_item.addr} < end_r[s]);
      ovl_vec[s] = valid_r[s] && nz_r[s] && ({1'b0, q_item.addr} < end_r[s]) &&
                   ({1'b0, base_r[s]} < q_item.end_addr);
    end
  end

  // Priority select: the lowest matching slot and the lowest free slot.
  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int s = REGIONS - 1; s >= 0; s--) begin
      if (cov_r[s]) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(s);
      end
      if (!valid_r[s]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(s);
      end
    end
  end

  always_comb begin
    status_nxt   = ST_NOT_MAPPED;
    hit_nxt      = 1'b0;
    index_nxt    = '0;
    offset_nxt   = '0;
    kind_out_nxt = '0;
    do_map       = 1'b0;
    do_unmap     = 1'b0;
    if (item_r.is_access) begin
      if (hit_any) begin
        hit_nxt      = 1'b1;
        index_nxt    = 4'(hit_idx);
        kind_out_nxt = kind_r[hit_idx];
        if (item_r.need_wr ? perm_r[hit_idx][1] : perm_r[hit_idx][0]) begin
          status_nxt = ST_OK;
          offset_nxt = item_r.addr - base_r[hit_idx];
        end else begin
          status_nxt = ST_PERM;
        end
      end
    end else if (item_r.is_map) begin
      if (ovl_r) begin
        status_nxt = ST_OVERLAP;
      end else if (!free_any) begin
        status_nxt = ST_FULL;
      end else begin
        do_map       = 1'b1;
        status_nxt   = ST_OK;
        hit_nxt      = 1'b1;
        index_nxt    = 4'(free_idx);
        kind_out_nxt = item_r.kind;
      end
    end else if (item_r.is_unmap) begin
      if (hit_any) begin
        do_unmap     = 1'b1;
        status_nxt   = ST_OK;
        hit_nxt      = 1'b1;
        index_nxt    = 4'(hit_idx);
        kind_out_nxt = kind_r[hit_idx];
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (mon.eval && do_map) begin
      valid_nxt[free_idx] = 1'b1;
    end
    if (mon.eval && do_unmap) begin
      valid_nxt[hit_idx] = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (mon.eval) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mon.pop) begin
      item_r <= q_item;
      cov_r  <= cov_nxt;
      ovl_r  <= q_item.len_nz && (|ovl_vec);
    end
    if (mon.eval) begin
      status_r   <= status_nxt;
      hit_r      <= hit_nxt;
      index_r    <= index_nxt;
      offset_r   <= offset_nxt;
      kind_out_r <= kind_out_nxt;
    end
    if (mon.eval && do_map) begin
      base_r[free_idx] <= item_r.addr;
      end_r[free_idx]  <= item_r.end_addr;
      nz_r[free_idx]   <= item_r.len_nz;
      perm_r[free_idx] <= item_r.perm;
      kind_r[free_idx] <= item_r.kind;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.hit          = hit_r;
  assign out_ch.region_index = index_r;
  assign out_ch.offset       = offset_r;
  assign out_ch.kind_out     = kind_out_r;

endmodule

/* design/region_table_address_decoder_unit.sv */
// Usage notes for the region table address decoder unit.
// Requests arrive on in_ch (valid/ready): a read or write access, a map of a
// new region or an unmap. Each request transaction yields exactly one result
// transaction on out_ch (valid/ready) with status, hit, region index, offset
// and backing kind. A front end decodes requests into a two-entry queue; a
// back end holding the region table takes one item at a time.
// A taken request is written to the queue; the back end pops it into its
// compare register, and the select step then writes the result register.
// The back end has two steps: a parallel compare against all slots, then
// priority select, table update and result write, which must finish before
// the next item is compared.
// Reset (synchronous, rst_n low) empties the table and the queue and drops
// any pending result; no clearing pass is needed.
// When the receiver stalls, the result holds in its register, the queue keeps
// accepting until it is full, and in_ch.ready then drops.
`timescale 1ns / 1ps
`include "region_table_address_decoder_unit_assert.svh"

module region_table_address_decoder_unit
  import rtad_pkg::*;
#(
  parameter int REGIONS = REGIONS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rtad_in_if.sink    in_ch,
  rtad_out_if.source out_ch
);

  item_t   front_item;
  item_t   q_item;
  logic    push;
  logic    q_full;
  logic    q_empty;
  bk_mon_t mon;

  rtad_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .item   (front_item)
  );

  rtad_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (front_item),
    .pop     (mon.pop),
    .rd_item (q_item),
    .full    (q_full),
    .empty   (q_empty)
  );

  rtad_back #(
    .REGIONS (REGIONS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_item  (q_item),
    .mon     (mon),
    .out_ch  (out_ch)
  );

  // The select step always finds the result register free.
  `RTAD_ASSERT(a_eval_out_free, mon.eval, !out_ch.valid)
  // An item taken from the queue is evaluated in the following cycle.
  `RTAD_ASSERT_NEXT(a_pop_then_eval, mon.pop, mon.eval && !mon.pop)
  // Hit is set exactly for successful results and permission failures.
  `RTAD_ASSERT(a_hit_status, out_ch.valid,
               out_ch.hit == ((out_ch.status == ST_OK) || (out_ch.status == ST_PERM)))
  // Nothing is taken from an empty queue.
  `RTAD_ASSERT(a_no_pop_empty, mon.pop, !q_empty)

endmodule
